// ===== design/qrs_pkg.sv =====
// Shared types and status codes for the quadratic root solver.
package qrs_pkg;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_DEGEN = 2'd1,
    STATUS_SAT   = 2'd2
  } qrs_status_t;

  // Classification of one request as it leaves the front part.
  typedef struct packed {
    logic degen;   // a is zero
    logic sa;      // sign of a
    logic sb;      // sign of b
    logic sd;      // discriminant is negative
  } qrs_flags_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } qrs_qstat_t;

  localparam int QUEUE_DEPTH = 4;

endpackage

// ===== design/qrs_front.sv =====
// Front part: accepts coefficients, forms the discriminant magnitude and classifies the request.
module qrs_front import qrs_pkg::*; #(
  parameter int COEF_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [COEF_WIDTH-1:0]   in_coef_a,
  input  logic [COEF_WIDTH-1:0]   in_coef_b,
  input  logic [COEF_WIDTH-1:0]   in_coef_c,
  input  logic                    q_room,
  output logic                    f_valid,
  output qrs_flags_t              f_flags,
  output logic [COEF_WIDTH-1:0]   f_ma,
  output logic [COEF_WIDTH-1:0]   f_mb,
  output logic [2*COEF_WIDTH:0]   f_dmag
);

  localparam int W  = COEF_WIDTH;
  localparam int L  = W / 2;
  localparam int H  = W - L;
  localparam int PW = 2 * W;
  localparam int DW = 2 * W + 1;

  logic          en;
  logic          v1_r, v2_r, v3_r, v4_r;

  // Stage 1: sign and magnitude.
  logic          sa1_r, sb1_r, sc1_r;
  logic [W-1:0]  ma1_r, mb1_r, mc1_r;
  logic [W-1:0]  ma1_nxt, mb1_nxt, mc1_nxt;

  // Stage 2: partial products.
  logic          sa2_r, sb2_r, opp2_r, degen2_r;
  logic [W-1:0]  ma2_r, mb2_r;
  logic [2*H-1:0] bb_hh_r, ac_hh_r;
  logic [H+L-1:0] bb_hl_r, ac_hl_r, ac_lh_r;
  logic [2*L-1:0] bb_ll_r, ac_ll_r;

  // Stage 3: full products.
  logic          sa3_r, sb3_r, opp3_r, degen3_r;
  logic [W-1:0]  ma3_r, mb3_r;
  logic [PW-1:0] b2_r, ac_r;
  logic [PW-1:0] b2_nxt, ac_nxt;

  // Stage 4: discriminant.
  qrs_flags_t    flags4_r;
  logic [W-1:0]  ma4_r, mb4_r;
  logic [DW-1:0] dmag4_r;
  logic [DW-1:0] dmag4_nxt, b2x, ac4;
  logic          sd4_nxt;

  assign en       = !v4_r || q_room;
  assign in_stall = !en;

  assign ma1_nxt = in_coef_a[W-1] ? (~in_coef_a + W'(1)) : in_coef_a;
  assign mb1_nxt = in_coef_b[W-1] ? (~in_coef_b + W'(1)) : in_coef_b;
  assign mc1_nxt = in_coef_c[W-1] ? (~in_coef_c + W'(1)) : in_coef_c;

  assign b2_nxt = (PW'(bb_hh_r) << (2 * L)) + (PW'(bb_hl_r) << (L + 1)) + PW'(bb_ll_r);
  assign ac_nxt = (PW'(ac_hh_r) << (2 * L)) + ((PW'(ac_hl_r) + PW'(ac_lh_r)) << L)
                + PW'(ac_ll_r);

  assign b2x = DW'(b2_r);
  assign ac4 = DW'({ac_r, 2'b00});

  always_comb begin
    if (opp3_r) begin
      dmag4_nxt = b2x + ac4;
      sd4_nxt   = 1'b0;
    end else if (b2x >= ac4) begin
      dmag4_nxt = b2x - ac4;
      sd4_nxt   = 1'b0;
    end else begin
      dmag4_nxt = ac4 - b2x;
      sd4_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa1_r <= in_coef_a[W-1];
      sb1_r <= in_coef_b[W-1];
      sc1_r <= in_coef_c[W-1];
      ma1_r <= ma1_nxt;
      mb1_r <= mb1_nxt;
      mc1_r <= mc1_nxt;

      sa2_r    <= sa1_r;
      sb2_r    <= sb1_r;
      opp2_r   <= sa1_r != sc1_r;
      degen2_r <= ma1_r == '0;
      ma2_r    <= ma1_r;
      mb2_r    <= mb1_r;
      bb_hh_r  <= mb1_r[W-1:L] * mb1_r[W-1:L];
      bb_hl_r  <= mb1_r[W-1:L] * mb1_r[L-1:0];
      bb_ll_r  <= mb1_r[L-1:0] * mb1_r[L-1:0];
      ac_hh_r  <= ma1_r[W-1:L] * mc1_r[W-1:L];
      ac_hl_r  <= ma1_r[W-1:L] * mc1_r[L-1:0];
      ac_lh_r  <= ma1_r[L-1:0] * mc1_r[W-1:L];
      ac_ll_r  <= ma1_r[L-1:0] * mc1_r[L-1:0];

      sa3_r    <= sa2_r;
      sb3_r    <= sb2_r;
      opp3_r   <= opp2_r;
      degen3_r <= degen2_r;
      ma3_r    <= ma2_r;
      mb3_r    <= mb2_r;
      b2_r     <= b2_nxt;
      ac_r     <= ac_nxt;

      flags4_r.degen <= degen3_r;
      flags4_r.sa    <= sa3_r;
      flags4_r.sb    <= sb3_r;
      flags4_r.sd    <= sd4_nxt;
      ma4_r          <= ma3_r;
      mb4_r          <= mb3_r;
      dmag4_r        <= dmag4_nxt;
    end
  end

  assign f_valid = v4_r;
  assign f_flags = flags4_r;
  assign f_ma    = ma4_r;
  assign f_mb    = mb4_r;
  assign f_dmag  = dmag4_r;

endmodule

// ===== design/qrs_queue.sv =====
// Short queue that decouples the front part from the back part.
module qrs_queue import qrs_pkg::*; #(
  parameter int DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  pop,
  output logic [DATA_WIDTH-1:0] rdata,
  output qrs_qstat_t            stat
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [DATA_WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  rvalid_r;
  logic [PW-1:0]         head_r, tail_r;
  logic [PW:0]           count_r;
  logic                  load, from_mem, bypass, to_mem;

  // The head request sits in an output register; the memory holds the rest.
  assign load     = !rvalid_r || pop;
  assign from_mem = load && count_r != '0;
  assign bypass   = load && count_r == '0 && push;
  assign to_mem   = push && !bypass;

  assign rdata          = rdata_r;
  assign stat.not_empty = rvalid_r;
  assign stat.not_full  = (count_r + (PW+1)'(rvalid_r)) != (PW+1)'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (to_mem) begin
        tail_r <= tail_r + PW'(1);
      end
      if (from_mem) begin
        head_r <= head_r + PW'(1);
      end
      if (to_mem && !from_mem) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (from_mem && !to_mem) begin
        count_r <= count_r - (PW+1)'(1);
      end
      if (load) begin
        rvalid_r <= from_mem || bypass;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (to_mem) begin
      mem_r[tail_r] <= wdata;
    end
    if (from_mem) begin
      rdata_r <= mem_r[head_r];
    end else if (bypass) begin
      rdata_r <= wdata;
    end
  end

endmodule

// ===== design/qrs_back.sv =====
// Back part: square root pipeline, numerators, divider pipeline and saturation.
module qrs_back import qrs_pkg::*; #(
  parameter int COEF_WIDTH,
  parameter int FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  qrs_flags_t            q_flags,
  input  logic [COEF_WIDTH-1:0] q_ma,
  input  logic [COEF_WIDTH-1:0] q_mb,
  input  logic [2*COEF_WIDTH:0] q_dmag,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COEF_WIDTH-1:0] out_first_real,
  output logic [COEF_WIDTH-1:0] out_first_imag,
  output logic [COEF_WIDTH-1:0] out_second_real,
  output logic [COEF_WIDTH-1:0] out_second_imag,
  output logic                  out_roots_complex,
  output logic [1:0]            out_status
);

  localparam int W     = COEF_WIDTH;
  localparam int SW    = W + 1;
  localparam int RW    = 2 * SW;
  localparam int REMW  = SW + 2;
  localparam int NMW   = W + 2;
  localparam int NW    = NMW + FRAC_BITS;
  localparam int DENW  = W + 1;
  localparam int DREMW = W + 2;

  logic en;

  assign en  = !out_valid || !out_stall;
  assign pop = en && q_valid;

  // Square root, one root bit per stage.
  logic            sq_v_r     [SW];
  qrs_flags_t      sq_flags_r [SW];
  logic [W-1:0]    sq_ma_r    [SW];
  logic [W-1:0]    sq_mb_r    [SW];
  logic [RW-1:0]   sq_rad_r   [SW];
  logic [REMW-1:0] sq_rem_r   [SW];
  logic [SW-1:0]   sq_root_r  [SW];

  for (genvar k = 0; k < SW; k++) begin : g_sq
    logic            v_in;
    qrs_flags_t      flags_in;
    logic [W-1:0]    ma_in, mb_in;
    logic [RW-1:0]   rad_in;
    logic [REMW-1:0] rem_in, rem_sh, trial;
    logic [SW-1:0]   root_in;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in     = q_valid;
      assign flags_in = q_flags;
      assign ma_in    = q_ma;
      assign mb_in    = q_mb;
      assign rad_in   = RW'(q_dmag);
      assign rem_in   = '0;
      assign root_in  = '0;
    end else begin : g_next
      assign v_in     = sq_v_r[k-1];
      assign flags_in = sq_flags_r[k-1];
      assign ma_in    = sq_ma_r[k-1];
      assign mb_in    = sq_mb_r[k-1];
      assign rad_in   = sq_rad_r[k-1];
      assign rem_in   = sq_rem_r[k-1];
      assign root_in  = sq_root_r[k-1];
    end

    assign rem_sh = {rem_in[REMW-3:0], rad_in[RW-1:RW-2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (en) begin
        sq_v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_flags_r[k] <= flags_in;
        sq_ma_r[k]    <= ma_in;
        sq_mb_r[k]    <= mb_in;
        sq_rad_r[k]   <= rad_in << 2;
        sq_rem_r[k]   <= ge ? (rem_sh - trial) : rem_sh;
        sq_root_r[k]  <= {root_in[SW-2:0], ge};
      end
    end
  end

  // Numerators in sign and magnitude, with the sign of each quotient.
  logic           nm_v_r;
  qrs_flags_t     nm_flags_r;
  logic [W-1:0]   nm_ma_r;
  logic [NMW-1:0] nm_num1_r, nm_num2_r;
  logic           nm_neg1_r, nm_neg2_r;

  qrs_flags_t     sf;
  logic [NMW-1:0] mbx, sx, sum_ms, mb_less_s, s_less_mb;
  logic           mb_ge_s, nb;
  logic [NMW-1:0] num1_nxt, num2_nxt;
  logic           sn1, sn2;

  assign sf        = sq_flags_r[SW-1];
  assign nb        = !sf.sb;
  assign mbx       = NMW'(sq_mb_r[SW-1]);
  assign sx        = NMW'(sq_root_r[SW-1]);
  assign sum_ms    = mbx + sx;
  assign mb_ge_s   = mbx >= sx;
  assign mb_less_s = mbx - sx;
  assign s_less_mb = sx - mbx;

  always_comb begin
    if (sf.sd) begin
      num1_nxt = mbx;
      sn1      = nb;
      num2_nxt = sx;
      sn2      = 1'b0;
    end else begin
      if (!nb) begin
        num1_nxt = sum_ms;
        sn1      = 1'b0;
      end else if (mb_ge_s) begin
        num1_nxt = mb_less_s;
        sn1      = 1'b1;
      end else begin
        num1_nxt = s_less_mb;
        sn1      = 1'b0;
      end
      if (nb) begin
        num2_nxt = sum_ms;
        sn2      = 1'b1;
      end else if (mb_ge_s) begin
        num2_nxt = mb_less_s;
        sn2      = 1'b0;
      end else begin
        num2_nxt = s_less_mb;
        sn2      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_v_r <= 1'b0;
    end else if (en) begin
      nm_v_r <= sq_v_r[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm_flags_r <= sf;
      nm_ma_r    <= sq_ma_r[SW-1];
      nm_num1_r  <= num1_nxt;
      nm_num2_r  <= num2_nxt;
      nm_neg1_r  <= sn1 ^ sf.sa;
      nm_neg2_r  <= sn2 ^ sf.sa;
    end
  end

  // Restoring division by 2a, two lanes, one quotient bit per stage.
  logic             dv_v_r     [NW];
  qrs_flags_t       dv_flags_r [NW];
  logic [W-1:0]     dv_ma_r    [NW];
  logic             dv_neg1_r  [NW];
  logic             dv_neg2_r  [NW];
  logic [NW-1:0]    dv_num1_r  [NW];
  logic [NW-1:0]    dv_num2_r  [NW];
  logic [DREMW-1:0] dv_rem1_r  [NW];
  logic [DREMW-1:0] dv_rem2_r  [NW];
  logic [NW-1:0]    dv_quo1_r  [NW];
  logic [NW-1:0]    dv_quo2_r  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_dv
    logic             v_in, neg1_in, neg2_in;
    qrs_flags_t       flags_in;
    logic [W-1:0]     ma_in;
    logic [NW-1:0]    num1_in, num2_in, quo1_in, quo2_in;
    logic [DREMW-1:0] rem1_in, rem2_in, rem1_sh, rem2_sh, den;
    logic             ge1, ge2;

    if (k == 0) begin : g_first
      assign v_in     = nm_v_r;
      assign flags_in = nm_flags_r;
      assign ma_in    = nm_ma_r;
      assign neg1_in  = nm_neg1_r;
      assign neg2_in  = nm_neg2_r;
      assign num1_in  = NW'(nm_num1_r) << FRAC_BITS;
      assign num2_in  = NW'(nm_num2_r) << FRAC_BITS;
      assign rem1_in  = '0;
      assign rem2_in  = '0;
      assign quo1_in  = '0;
      assign quo2_in  = '0;
    end else begin : g_next
      assign v_in     = dv_v_r[k-1];
      assign flags_in = dv_flags_r[k-1];
      assign ma_in    = dv_ma_r[k-1];
      assign neg1_in  = dv_neg1_r[k-1];
      assign neg2_in  = dv_neg2_r[k-1];
      assign num1_in  = dv_num1_r[k-1];
      assign num2_in  = dv_num2_r[k-1];
      assign rem1_in  = dv_rem1_r[k-1];
      assign rem2_in  = dv_rem2_r[k-1];
      assign quo1_in  = dv_quo1_r[k-1];
      assign quo2_in  = dv_quo2_r[k-1];
    end

    assign den     = DREMW'({ma_in, 1'b0});
    assign rem1_sh = {rem1_in[DREMW-2:0], num1_in[NW-1]};
    assign rem2_sh = {rem2_in[DREMW-2:0], num2_in[NW-1]};
    assign ge1     = rem1_sh >= den;
    assign ge2     = rem2_sh >= den;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (en) begin
        dv_v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_flags_r[k] <= flags_in;
        dv_ma_r[k]    <= ma_in;
        dv_neg1_r[k]  <= neg1_in;
        dv_neg2_r[k]  <= neg2_in;
        dv_num1_r[k]  <= num1_in << 1;
        dv_num2_r[k]  <= num2_in << 1;
        dv_rem1_r[k]  <= ge1 ? (rem1_sh - den) : rem1_sh;
        dv_rem2_r[k]  <= ge2 ? (rem2_sh - den) : rem2_sh;
        dv_quo1_r[k]  <= {quo1_in[NW-2:0], ge1};
        dv_quo2_r[k]  <= {quo2_in[NW-2:0], ge2};
      end
    end
  end

  // Clamp a quotient magnitude to the signed range; the top bit flags saturation.
  function automatic logic [W:0] sat_q(input logic [NW-1:0] q, input logic neg);
    logic [NW-1:0] half;
    logic [W:0]    res;
    half = NW'(1) << (W - 1);
    if (neg) begin
      if (q > half) begin
        res = {1'b1, 1'b1, {(W-1){1'b0}}};
      end else begin
        res = {1'b0, ~q[W-1:0] + W'(1)};
      end
    end else begin
      if (q > half - NW'(1)) begin
        res = {1'b1, 1'b0, {(W-1){1'b1}}};
      end else begin
        res = {1'b0, q[W-1:0]};
      end
    end
    return res;
  endfunction

  qrs_flags_t    lf;
  logic [W:0]    r1, r2, r2n;
  logic [W-1:0]  fr_nxt, fi_nxt, sr_nxt, si_nxt;
  logic          cx_nxt;
  qrs_status_t   st_nxt;

  assign lf  = dv_flags_r[NW-1];
  assign r1  = sat_q(dv_quo1_r[NW-1], dv_neg1_r[NW-1]);
  assign r2  = sat_q(dv_quo2_r[NW-1], dv_neg2_r[NW-1]);
  assign r2n = sat_q(dv_quo2_r[NW-1], !dv_neg2_r[NW-1]);

  always_comb begin
    if (lf.degen) begin
      fr_nxt = '0;
      fi_nxt = '0;
      sr_nxt = '0;
      si_nxt = '0;
      cx_nxt = 1'b0;
      st_nxt = STATUS_DEGEN;
    end else if (lf.sd) begin
      fr_nxt = r1[W-1:0];
      sr_nxt = r1[W-1:0];
      fi_nxt = r2[W-1:0];
      si_nxt = r2n[W-1:0];
      cx_nxt = 1'b1;
      st_nxt = (r1[W] || r2[W] || r2n[W]) ? STATUS_SAT : STATUS_OK;
    end else begin
      fr_nxt = r1[W-1:0];
      sr_nxt = r2[W-1:0];
      fi_nxt = '0;
      si_nxt = '0;
      cx_nxt = 1'b0;
      st_nxt = (r1[W] || r2[W]) ? STATUS_SAT : STATUS_OK;
    end
  end

  logic          out_valid_r;
  logic [W-1:0]  fr_r, fi_r, sr_r, si_r;
  logic          cx_r;
  qrs_status_t   st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v_r[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fr_r <= fr_nxt;
      fi_r <= fi_nxt;
      sr_r <= sr_nxt;
      si_r <= si_nxt;
      cx_r <= cx_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_first_real    = fr_r;
  assign out_first_imag    = fi_r;
  assign out_second_real   = sr_r;
  assign out_second_imag   = si_r;
  assign out_roots_complex = cx_r;
  assign out_status        = st_r;

endmodule

// ===== design/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: front part, queue and back part.
//
//   Channel   Ports                                          Direction
//   in        in_valid, in_stall, in_coef_a/b/c              request in
//   out       out_valid, out_stall, out_first/second_real,   result out
//             out_first/second_imag, out_roots_complex, out_status
//
// One request per cycle is sustained while out_stall is low. A request passes four front
// stages, the queue, COEF_WIDTH+1 square root stages, one numerator stage,
// COEF_WIDTH+2+FRAC_BITS divider stages and the output register.
// Reset clears only the valid bits and the queue pointers and count; no clearing pass is needed.
// A stalled output holds the back part; the front keeps accepting until the four-entry
// queue fills, and only then raises in_stall.
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COEF_WIDTH-1:0] in_coef_a,
  input  logic [COEF_WIDTH-1:0] in_coef_b,
  input  logic [COEF_WIDTH-1:0] in_coef_c,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COEF_WIDTH-1:0] out_first_real,
  output logic [COEF_WIDTH-1:0] out_first_imag,
  output logic [COEF_WIDTH-1:0] out_second_real,
  output logic [COEF_WIDTH-1:0] out_second_imag,
  output logic                  out_roots_complex,
  output logic [1:0]            out_status
);

  localparam int W  = COEF_WIDTH;
  localparam int DW = 2 * W + 1;
  localparam int QW = $bits(qrs_flags_t) + 2 * W + DW;

  logic          f_valid;
  qrs_flags_t    f_flags;
  logic [W-1:0]  f_ma, f_mb;
  logic [DW-1:0] f_dmag;

  qrs_qstat_t    q_stat;
  logic          push, pop;
  logic [QW-1:0] q_wdata, q_rdata;
  qrs_flags_t    q_flags;
  logic [W-1:0]  q_ma, q_mb;
  logic [DW-1:0] q_dmag;

  qrs_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_coef_a (in_coef_a),
    .in_coef_b (in_coef_b),
    .in_coef_c (in_coef_c),
    .q_room    (q_stat.not_full),
    .f_valid   (f_valid),
    .f_flags   (f_flags),
    .f_ma      (f_ma),
    .f_mb      (f_mb),
    .f_dmag    (f_dmag)
  );

  assign push    = f_valid && q_stat.not_full;
  assign q_wdata = {f_flags, f_ma, f_mb, f_dmag};
  assign {q_flags, q_ma, q_mb, q_dmag} = q_rdata;

  qrs_queue #(.DATA_WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .pop   (pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  qrs_back #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_stat.not_empty),
    .q_flags           (q_flags),
    .q_ma              (q_ma),
    .q_mb              (q_mb),
    .q_dmag            (q_dmag),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_first_real    (out_first_real),
    .out_first_imag    (out_first_imag),
    .out_second_real   (out_second_real),
    .out_second_imag   (out_second_imag),
    .out_roots_complex (out_roots_complex),
    .out_status        (out_status)
  );

endmodule
